FILE: rtl/cle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_pkg: shared definitions of the cursor linked list engine
// Pool geometry, operation and status codes, word types and slot helpers.
// ----------------------------------------------------------------------------
package cle_pkg;

	localparam int POOL_DEPTH   = 32;
	localparam int IDX_W        = $clog2(POOL_DEPTH + 1);
	localparam int ADDR_W       = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int NODE_COUNT_W = 6;

	// index that points nowhere
	localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(POOL_DEPTH);

	localparam logic [3:0] OP_CLEAR   = 4'd0;
	localparam logic [3:0] OP_APPEND  = 4'd1;
	localparam logic [3:0] OP_REWIND  = 4'd2;
	localparam logic [3:0] OP_ADVANCE = 4'd3;
	localparam logic [3:0] OP_READ    = 4'd4;
	localparam logic [3:0] OP_DELETE  = 4'd5;
	localparam logic [3:0] OP_TAKE    = 4'd6;
	localparam logic [3:0] OP_CHANGE  = 4'd7;
	localparam logic [3:0] OP_INSERT  = 4'd8;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_REFUSED = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;
	localparam logic [1:0] STAT_SKIPPED = 2'd3;

	localparam logic [7:0] NUL_BYTE  = 8'h00;
	localparam logic [7:0] SKIP_BYTE = 8'hFE;

	typedef struct packed {
		logic [3:0] operation;
		logic [7:0] char_value;
	} cmd_word_t;

	typedef struct packed {
		logic [7:0]              value;
		logic [1:0]              status;
		logic                    list_empty;
		logic                    at_end;
		logic [NODE_COUNT_W-1:0] node_count;
	} rsp_word_t;

	function automatic logic is_slot(input logic [IDX_W-1:0] idx);
		return idx < NULL_IDX;
	endfunction

	// lowest free slot of the pool, null when every slot is taken
	function automatic logic [IDX_W-1:0] lowest_free(input logic [POOL_DEPTH-1:0] used);
		logic [IDX_W-1:0] r;
		r = NULL_IDX;
		for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
			if (!used[i]) begin
				r = IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

FILE: rtl/cle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cle_ram: generic simple dual-port RAM
// One write port, one registered read port with a read enable.
// ----------------------------------------------------------------------------
module cle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read data holds while re is low
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/cursor_linked_list_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_unit: singly linked character list with cursor
// Node pool in two RAMs (characters and links), cursor ops on the next node.
// ----------------------------------------------------------------------------
// usage
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one operation word;
//   rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one result word
//   per command, in command order
//   a command passes through accept, issue (ram reads or first writes) and
//   commit (second link write and register update); the ram read port is
//   registered, so data read in issue is used in commit; cmd_stall is high
//   through issue and commit, so a new command is taken only after the last commits
//   rsp_valid rises at the edge that completes commit, when the result word
//   is loaded into the response register
//   the response register decouples the two sides: a command is accepted
//   while the previous result still waits; if rsp is stalled when the next
//   result is due, commit holds (no writes) until the register frees up
//   reset clears the list, cursor, counters and slot map at once; the node
//   rams need no clearing since only linked slots are ever read
// ----------------------------------------------------------------------------
module cursor_linked_list_engine_unit
	import cle_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_word_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_word_t rsp
);

	// sequencer codes
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_ISSUE  = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;

	logic [1:0] state_q, state_d;

	// command held for the duration of its work
	logic [3:0] op_q;
	logic [7:0] ch_q;

	// list registers; cnext_q mirrors the link of the cursor node
	logic [IDX_W-1:0]      head_q, head_d;
	logic [IDX_W-1:0]      tail_q, tail_d;
	logic [IDX_W-1:0]      cur_q, cur_d;
	logic [IDX_W-1:0]      cnext_q, cnext_d;
	logic [IDX_W-1:0]      count_q, count_d;
	logic [POOL_DEPTH-1:0] used_q, used_d;
	logic [IDX_W-1:0]      free_q;

	// ram ports
	logic              char_we, char_re;
	logic [ADDR_W-1:0] char_waddr, char_raddr;
	logic [7:0]        char_wdata, char_rdata;
	logic              link_we, link_re;
	logic [ADDR_W-1:0] link_waddr, link_raddr;
	logic [IDX_W-1:0]  link_wdata, link_rdata;

	logic      rsp_valid_q;
	rsp_word_t rsp_q, rsp_d;
	logic      go;
	logic      commit;
	logic      ch_ok;

	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// commit may proceed once the response register can take the result
	assign go    = !rsp_valid_q || !rsp_stall;
	assign ch_ok = (ch_q != NUL_BYTE) && (ch_q != SKIP_BYTE);

	cle_ram #(.WIDTH(8), .DEPTH(POOL_DEPTH)) u_char_ram (
		.clk   (clk),
		.we    (char_we),
		.waddr (char_waddr),
		.wdata (char_wdata),
		.re    (char_re),
		.raddr (char_raddr),
		.rdata (char_rdata)
	);

	cle_ram #(.WIDTH(IDX_W), .DEPTH(POOL_DEPTH)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	always_comb begin
		char_we    = 1'b0;
		char_re    = 1'b0;
		char_waddr = free_q[ADDR_W-1:0];
		char_wdata = ch_q;
		char_raddr = cur_q[ADDR_W-1:0];
		link_we    = 1'b0;
		link_re    = 1'b0;
		link_waddr = free_q[ADDR_W-1:0];
		link_wdata = NULL_IDX;
		link_raddr = cnext_q[ADDR_W-1:0];
		head_d     = head_q;
		tail_d     = tail_q;
		cur_d      = cur_q;
		cnext_d    = cnext_q;
		count_d    = count_q;
		used_d     = used_q;
		commit     = 1'b0;
		rsp_d      = '0;
		rsp_d.status = STAT_OK;

		// issue: reads of the nodes involved, or writes of a fresh node
		if (state_q == S_ISSUE) begin
			unique case (op_q) inside
				OP_APPEND: begin
					if (ch_ok && is_slot(free_q)) begin
						char_we = 1'b1;
						link_we = 1'b1;
					end
				end
				OP_REWIND: begin
					link_re    = is_slot(head_q);
					link_raddr = head_q[ADDR_W-1:0];
				end
				OP_ADVANCE: begin
					link_re = is_slot(cnext_q);
				end
				OP_READ: begin
					char_re = is_slot(cur_q);
				end
				OP_DELETE, OP_TAKE: begin
					link_re    = is_slot(cnext_q);
					char_re    = is_slot(cnext_q);
					char_raddr = cnext_q[ADDR_W-1:0];
				end
				OP_CHANGE: begin
					char_we    = is_slot(cnext_q);
					char_waddr = cnext_q[ADDR_W-1:0];
				end
				OP_INSERT: begin
					if (is_slot(cur_q) && is_slot(free_q)) begin
						char_we    = 1'b1;
						link_we    = 1'b1;
						link_wdata = cnext_q;
					end
				end
				default: begin
				end
			endcase
		end

		// commit: relinking and register update, result formed from new state
		if ((state_q == S_COMMIT) && go) begin
			commit = 1'b1;
			unique case (op_q) inside
				OP_CLEAR: begin
					used_d  = '0;
					head_d  = NULL_IDX;
					tail_d  = NULL_IDX;
					cur_d   = NULL_IDX;
					cnext_d = NULL_IDX;
					count_d = '0;
				end
				OP_APPEND: begin
					if (!ch_ok) begin
						rsp_d.status = STAT_SKIPPED;
					end else if (!is_slot(free_q)) begin
						rsp_d.status = STAT_FULL;
					end else begin
						if (is_slot(tail_q)) begin
							link_we    = 1'b1;
							link_waddr = tail_q[ADDR_W-1:0];
							link_wdata = free_q;
							if (tail_q == cur_q) begin
								cnext_d = free_q;
							end
						end else begin
							// first node of an empty list takes the cursor
							head_d  = free_q;
							cur_d   = free_q;
							cnext_d = NULL_IDX;
						end
						tail_d  = free_q;
						count_d = count_q + 1'b1;
						used_d[free_q[ADDR_W-1:0]] = 1'b1;
					end
				end
				OP_REWIND: begin
					cur_d   = head_q;
					cnext_d = is_slot(head_q) ? link_rdata : NULL_IDX;
				end
				OP_ADVANCE: begin
					if (is_slot(cnext_q)) begin
						cur_d   = cnext_q;
						cnext_d = link_rdata;
					end else begin
						rsp_d.status = STAT_REFUSED;
					end
				end
				OP_READ: begin
					if (is_slot(cur_q)) begin
						rsp_d.value = char_rdata;
					end else begin
						rsp_d.status = STAT_REFUSED;
					end
				end
				OP_DELETE, OP_TAKE: begin
					if (is_slot(cnext_q)) begin
						link_we    = 1'b1;
						link_waddr = cur_q[ADDR_W-1:0];
						link_wdata = link_rdata;
						cnext_d    = link_rdata;
						used_d[cnext_q[ADDR_W-1:0]] = 1'b0;
						// removing the tail leaves the cursor node as tail
						if (tail_q == cnext_q) begin
							tail_d = cur_q;
						end
						if (count_q != '0) begin
							count_d = count_q - 1'b1;
						end
						if (op_q == OP_TAKE) begin
							rsp_d.value = char_rdata;
						end
					end else begin
						rsp_d.status = STAT_REFUSED;
					end
				end
				OP_CHANGE: begin
					if (!is_slot(cnext_q)) begin
						rsp_d.status = STAT_REFUSED;
					end
				end
				OP_INSERT: begin
					if (!is_slot(cur_q)) begin
						rsp_d.status = STAT_REFUSED;
					end else if (!is_slot(free_q)) begin
						rsp_d.status = STAT_FULL;
					end else begin
						link_we    = 1'b1;
						link_waddr = cur_q[ADDR_W-1:0];
						link_wdata = free_q;
						cnext_d    = free_q;
						if (tail_q == cur_q) begin
							tail_d = free_q;
						end
						count_d = count_q + 1'b1;
						used_d[free_q[ADDR_W-1:0]] = 1'b1;
					end
				end
				default: begin
					rsp_d.status = STAT_REFUSED;
				end
			endcase
			rsp_d.list_empty = (count_d == '0);
			rsp_d.at_end     = !(is_slot(cur_d) && is_slot(cnext_d));
			rsp_d.node_count = NODE_COUNT_W'(count_d);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					state_d = S_ISSUE;
				end
			end
			S_ISSUE: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (go) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= NULL_IDX;
			tail_q      <= NULL_IDX;
			cur_q       <= NULL_IDX;
			cnext_q     <= NULL_IDX;
			count_q     <= '0;
			used_q      <= '0;
			free_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			cur_q   <= cur_d;
			cnext_q <= cnext_d;
			count_q <= count_d;
			used_q  <= used_d;
			// free slot is registered from the slot map, settled before next issue
			free_q  <= lowest_free(used_q);
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			op_q <= cmd.operation;
			ch_q <= cmd.char_value;
		end
		if (commit) begin
			rsp_q <= rsp_d;
		end
	end

	// slot map and node count agree
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == int'(count_q))
		else $error("slot map and node count disagree");

	// an empty list has no head, tail or cursor
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> ((head_q == NULL_IDX) && (tail_q == NULL_IDX)
			&& (cur_q == NULL_IDX)))
		else $error("empty list still holds pointers");

	// an empty cursor has no successor
	assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q == NULL_IDX) |-> (cnext_q == NULL_IDX))
		else $error("successor without cursor");

	// the tail node never has a successor mirrored at the cursor
	assert property (@(posedge clk) disable iff (!arst_n)
		((cur_q == tail_q) && (cur_q != NULL_IDX)) |-> (cnext_q == NULL_IDX))
		else $error("cursor at tail but successor set");

	// a result is only loaded when the response register is free
	assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> (!rsp_valid_q || !rsp_stall))
		else $error("result overwrote a waiting word");

endmodule
